// File: rtl/pixel_edge_feature_extractor_macros.svh
// Assertion macros used by the edge feature extractor datapath.
// Plain text macros only; no dependencies.
`ifndef PIXEL_EDGE_FEATURE_EXTRACTOR_MACROS_SVH
`define PIXEL_EDGE_FEATURE_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PEFE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define PEFE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pefe_pkg.sv
// Types, constants and command/status structs of the edge feature extractor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pefe_pkg;

   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 1024;
   localparam int DIR_FRAC_BITS = 14;

   localparam int PIX_W   = 8;
   localparam int DIM_W   = 11;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = 11;
   localparam int OUT_W   = 10;
   localparam int MEM_DEPTH = 2 * MAX_WIDTH;
   localparam int ADDR_W  = $clog2(MEM_DEPTH);
   localparam int GRAD_W  = 9;
   localparam int SUM_W   = 17;
   localparam int RAD_W   = 30;
   localparam int MAG_W   = 15;
   localparam int REM_W   = 17;
   localparam int SQRT_STEPS = RAD_W / 2;
   localparam int DIR_W   = 16;
   localparam int DIV_SHIFT = DIR_FRAC_BITS + 6;
   localparam int NUM_W   = PIX_W + DIV_SHIFT + 1;
   localparam int Q_W     = DIR_FRAC_BITS + 3;
   localparam int ITER_W  = 5;
   localparam int DATA_OUT_W = 104;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
   localparam logic [DIM_W-1:0] MAX_W_DIM    = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_H_DIM    = DIM_W'(MAX_HEIGHT);

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      RD_CENTRE, RD_UP, RD_LEFT, RD_RIGHT
   } rd_sel_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PREP, S_RD_C, S_RD_U, S_RD_L, S_RD_R, S_RD_WAIT,
      S_CALC, S_SQRT, S_DIV_LOAD, S_DIV, S_DONE
   } state_type;

   typedef struct packed {
      logic       clear_step;
      logic       accept;
      logic       prep;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       calc;
      logic       sqrt_step;
      logic       div_load;
      logic       div_step;
      logic       finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic early;
      logic row_zero;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// File: rtl/pixel_edge_feature_extractor.sv
// Edge feature extractor top level: one item in flight. A pixel of row 0 or an
// early drain goes through prep and back to idle with no result and no reads.
// An item with a result goes through prep, 4 line-store reads, a wait, calc, 15
// root steps, a load, 17 divide steps and a hand-off that waits for the output
// register to be free; the next item is taken while the result waits. Synchronous
// active-high reset starts a clearing pass of the line store, no items taken during it.
`timescale 1ns / 1ps
`default_nettype none
module pixel_edge_feature_extractor
   import pefe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,  // pixel[7:0]
   input  wire logic                  req_tuser,  // operation
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // row[9:0], col[19:10], laplace_nonzero[20], grad_x[29:21], grad_y[38:30],
   // grad_mag[53:39], dir_x[69:54], dir_y[85:70], max_mag[100:86], zero[103:101]
   output logic [DATA_OUT_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [DIM_W-1:0]      csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   pefe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pefe_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_op     (req_tuser),
      .req_pix    (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// File: rtl/pefe_ctrl.sv
// Sequencer of the edge feature extractor: clearing pass, neighbor reads,
// square root and divide iterations, result hand-off. Uses pefe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pefe_ctrl
   import pefe_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      iter_in    = iter_ff;
      cmd        = '0;
      cmd.rd_sel = RD_CENTRE;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = (status.early || status.row_zero) ? S_IDLE : S_RD_C;
         end
         S_RD_C: begin
            cmd.rd_en = 1'b1;
            state_in  = S_RD_U;
         end
         S_RD_U: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_UP;
            state_in   = S_RD_L;
         end
         S_RD_L: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LEFT;
            state_in   = S_RD_R;
         end
         S_RD_R: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_RIGHT;
            state_in   = S_RD_WAIT;
         end
         S_RD_WAIT: state_in = S_CALC;
         S_CALC: begin
            cmd.calc = 1'b1;
            iter_in  = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            iter_in       = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(SQRT_STEPS - 1)) state_in = S_DIV_LOAD;
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            iter_in      = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(Q_W - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/pefe_dpath.sv
// Datapath of the edge feature extractor: line store, position and frame
// registers, bit-serial square root, two restoring dividers, output register.
// Uses pefe_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_edge_feature_extractor_macros.svh"
module pefe_dpath
   import pefe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          cmd,
   output dp_status_type              status,
   input  wire logic                  req_op,
   input  wire logic [PIX_W-1:0]      req_pix,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_index,
   input  wire logic [DIM_W-1:0]      csr_data,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [DATA_OUT_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   logic [PIX_W-1:0] mem [MEM_DEPTH];
   logic [PIX_W-1:0] rd_data_ff;
   rd_sel_type       rd_sel_ff;
   logic             rd_valid_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic             mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [PIX_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] clr_addr_ff;

   logic [DIM_W-1:0] w_ff, h_ff;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [MAG_W-1:0] frame_max_ff, frame_max_in;
   logic             drain_ff;
   logic             op_ff;
   logic [PIX_W-1:0] pix_ff;
   logic [PIX_W-1:0] centre_ff, up_ff, left_ff, right_ff;

   // wrap and advance of the input position
   logic             wrap;
   logic [COL_W-1:0] col_adj;
   logic [ROW_W-1:0] row_adj;
   logic             drain_now;
   logic [DIM_W-1:0] col_inc_adj, col_inc_cur;
   logic [ROW_W-1:0] rr;

   always_comb begin
      wrap      = {1'b0, in_col_ff} >= w_ff;
      col_adj   = wrap ? '0 : in_col_ff;
      row_adj   = in_row_ff + ROW_W'(wrap);
      drain_now = row_adj >= h_ff;
      col_inc_adj = {1'b0, col_adj} + 1'b1;
      col_inc_cur = {1'b0, in_col_ff} + 1'b1;
      rr        = in_row_ff - 1'b1;
      status.clear_last = clr_addr_ff == ADDR_W'(MEM_DEPTH - 1);
      status.early      = op_ff && !drain_now;
      status.row_zero   = row_adj == '0;
      status.out_free   = !rsp_tvalid || rsp_tready;
   end

   // read address per neighbor
   always_comb begin
      unique case (cmd.rd_sel)
         RD_CENTRE: rd_addr = {rr[0], in_col_ff};
         RD_UP:     rd_addr = {~rr[0], in_col_ff};
         RD_LEFT:   rd_addr = {rr[0], in_col_ff - 1'b1};
         RD_RIGHT:  rd_addr = {rr[0], in_col_ff + 1'b1};
         default:   rd_addr = {rr[0], in_col_ff};
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_addr_ff;
      mem_wdata = '0;
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.prep && !status.early && status.row_zero) begin
         mem_we    = 1'b1;
         mem_waddr = {1'b0, col_adj};
         mem_wdata = pix_ff;
      end else if (cmd.finish && !drain_ff) begin
         mem_we    = 1'b1;
         mem_waddr = {in_row_ff[0], in_col_ff};
         mem_wdata = pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd.rd_en) rd_data_ff <= mem[rd_addr];
      rd_sel_ff <= cmd.rd_sel;
   end

   // neighbor capture, in the cycle after the read
   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         case (rd_sel_ff)
            RD_CENTRE: centre_ff <= rd_data_ff;
            RD_UP:     up_ff     <= rd_data_ff;
            RD_LEFT:   left_ff   <= rd_data_ff;
            default:   right_ff  <= rd_data_ff;
         endcase
      end
      if (cmd.accept) begin
         op_ff  <= req_op;
         pix_ff <= req_pix;
      end
      if (cmd.prep) drain_ff <= drain_now;
   end

   // gradients and Laplacian
   logic [PIX_W-1:0]        up_v, left_v, right_v, down_v;
   logic [PIX_W+1:0]        nb_sum;
   logic signed [GRAD_W-1:0] gx, gy;
   logic signed [2*GRAD_W-1:0] sqx, sqy;
   logic [SUM_W-1:0]        sum;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic                    lap_nz_ff;

   always_comb begin
      up_v    = (rr != '0) ? up_ff : '0;
      left_v  = (in_col_ff != '0) ? left_ff : '0;
      right_v = (col_inc_cur < w_ff) ? right_ff : '0;
      down_v  = drain_ff ? '0 : pix_ff;
      nb_sum  = {2'b0, up_v} + {2'b0, left_v} + {2'b0, right_v} + {2'b0, down_v};
      gx      = $signed({1'b0, right_v}) - $signed({1'b0, centre_ff});
      gy      = $signed({1'b0, down_v}) - $signed({1'b0, centre_ff});
      sqx     = gx * gx;
      sqy     = gy * gy;
      sum     = {1'b0, sqx[15:0]} + {1'b0, sqy[15:0]};
   end

   // bit-serial square root, two radicand bits per step
   logic [RAD_W-1:0] rad_ff;
   logic [REM_W-1:0] srem_ff;
   logic [MAG_W-1:0] root_ff;
   logic [REM_W+1:0] srem_t, trial;

   always_comb begin
      srem_t = {srem_ff, rad_ff[RAD_W-1 -: 2]};
      trial  = {{(REM_W+2-MAG_W-2){1'b0}}, root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         gx_ff     <= gx;
         gy_ff     <= gy;
         lap_nz_ff <= nb_sum != {centre_ff, 2'b00};
         rad_ff    <= {1'b0, sum, 12'b0};
         srem_ff   <= '0;
         root_ff   <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (srem_t >= trial) begin
            srem_ff <= REM_W'(srem_t - trial);
            root_ff <= {root_ff[MAG_W-2:0], 1'b1};
         end else begin
            srem_ff <= srem_t[REM_W-1:0];
            root_ff <= {root_ff[MAG_W-2:0], 1'b0};
         end
      end
   end

   // restoring dividers for both direction components
   logic [PIX_W-1:0] absx, absy;
   logic [NUM_W-1:0] nx, ny;
   logic [MAG_W-1:0] drx_ff, dry_ff;
   logic [Q_W-1:0]   nmx_ff, nmy_ff, qx_ff, qy_ff;
   logic [MAG_W:0]   tx, ty;

   always_comb begin
      absx = gx_ff[GRAD_W-1] ? PIX_W'(-gx_ff) : gx_ff[PIX_W-1:0];
      absy = gy_ff[GRAD_W-1] ? PIX_W'(-gy_ff) : gy_ff[PIX_W-1:0];
      nx   = {1'b0, absx, {DIV_SHIFT{1'b0}}} + NUM_W'(root_ff[MAG_W-1:1]);
      ny   = {1'b0, absy, {DIV_SHIFT{1'b0}}} + NUM_W'(root_ff[MAG_W-1:1]);
      tx   = {drx_ff, nmx_ff[Q_W-1]};
      ty   = {dry_ff, nmy_ff[Q_W-1]};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         drx_ff <= MAG_W'(nx[NUM_W-1:Q_W]);
         dry_ff <= MAG_W'(ny[NUM_W-1:Q_W]);
         nmx_ff <= nx[Q_W-1:0];
         nmy_ff <= ny[Q_W-1:0];
         qx_ff  <= '0;
         qy_ff  <= '0;
      end else if (cmd.div_step) begin
         nmx_ff <= {nmx_ff[Q_W-2:0], 1'b0};
         nmy_ff <= {nmy_ff[Q_W-2:0], 1'b0};
         if (tx >= {1'b0, root_ff}) begin
            drx_ff <= MAG_W'(tx - {1'b0, root_ff});
            qx_ff  <= {qx_ff[Q_W-2:0], 1'b1};
         end else begin
            drx_ff <= tx[MAG_W-1:0];
            qx_ff  <= {qx_ff[Q_W-2:0], 1'b0};
         end
         if (ty >= {1'b0, root_ff}) begin
            dry_ff <= MAG_W'(ty - {1'b0, root_ff});
            qy_ff  <= {qy_ff[Q_W-2:0], 1'b1};
         end else begin
            dry_ff <= ty[MAG_W-1:0];
            qy_ff  <= {qy_ff[Q_W-2:0], 1'b0};
         end
      end
   end

   // result assembly
   localparam logic [Q_W-1:0] DIR_LIM = Q_W'(1) << DIR_FRAC_BITS;
   logic [DIR_W-1:0] satx, saty, dir_x, dir_y;
   logic [MAG_W-1:0] new_max;
   logic             last;

   always_comb begin
      satx  = (qx_ff > DIR_LIM) ? DIR_W'(DIR_LIM) : qx_ff[DIR_W-1:0];
      saty  = (qy_ff > DIR_LIM) ? DIR_W'(DIR_LIM) : qy_ff[DIR_W-1:0];
      dir_x = (root_ff == '0) ? '0 : (gx_ff[GRAD_W-1] ? DIR_W'(-satx) : satx);
      dir_y = (root_ff == '0) ? '0 : (gy_ff[GRAD_W-1] ? DIR_W'(-saty) : saty);
      new_max = (root_ff > frame_max_ff) ? root_ff : frame_max_ff;
      last    = drain_ff && (col_inc_cur >= w_ff);
   end

   // position and frame state
   always_comb begin
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      frame_max_in = frame_max_ff;
      if (cmd.prep) begin
         in_col_in = col_adj;
         in_row_in = row_adj;
         if (!status.early && status.row_zero) begin
            if (col_inc_adj >= w_ff) begin
               in_col_in = '0;
               in_row_in = row_adj + 1'b1;
            end else begin
               in_col_in = col_inc_adj[COL_W-1:0];
            end
         end
      end else if (cmd.finish) begin
         if (last) begin
            in_col_in    = '0;
            in_row_in    = '0;
            frame_max_in = '0;
         end else begin
            frame_max_in = new_max;
            if (col_inc_cur >= w_ff) begin
               in_col_in = '0;
               in_row_in = in_row_ff + 1'b1;
            end else begin
               in_col_in = col_inc_cur[COL_W-1:0];
            end
         end
      end
   end

   logic [DIM_W-1:0] csr_clamped;
   always_comb begin
      csr_clamped = (csr_data == '0) ? DIM_W'(1) : csr_data;
      if (csr_index == CSR_FRAME_WIDTH) begin
         if (csr_data > MAX_W_DIM) csr_clamped = MAX_W_DIM;
      end else begin
         if (csr_data > MAX_H_DIM) csr_clamped = MAX_H_DIM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         frame_max_ff <= '0;
         w_ff         <= RESET_WIDTH;
         h_ff         <= RESET_HEIGHT;
         rsp_tvalid   <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_addr_ff <= clr_addr_ff + 1'b1;
         rd_valid_ff  <= cmd.rd_en;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         frame_max_ff <= frame_max_in;
         if (csr_valid) begin
            if (csr_index == CSR_FRAME_WIDTH) w_ff <= csr_clamped;
            else h_ff <= csr_clamped;
         end
         if (cmd.finish) rsp_tvalid <= 1'b1;
         else if (rsp_tready) rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_tdata <= {3'b000, new_max, dir_y, dir_x, root_ff, gy_ff, gx_ff, lap_nz_ff,
                       in_col_ff, rr[OUT_W-1:0]};
         rsp_tlast <= last;
      end
   end

   `PEFE_ASSERT_IMP(a_max_covers_mag, clock, reset, rsp_tvalid,
      rsp_tdata[100:86] >= rsp_tdata[53:39], "frame maximum below magnitude")
   `PEFE_ASSERT_IMP(a_zero_mag_dir, clock, reset, rsp_tvalid && rsp_tdata[53:39] == '0,
      rsp_tdata[69:54] == '0 && rsp_tdata[85:70] == '0, "direction nonzero at zero magnitude")
   `PEFE_ASSERT_NXT(a_finish_shows, clock, reset, cmd.finish,
      rsp_tvalid && frame_max_ff <= rsp_tdata[100:86], "result not shown after finish")

endmodule
`default_nettype wire
